// File: design/clts_pkg.sv
// shared types and constants for the token scanner
package clts_pkg;

	typedef enum logic [3:0] {
		M_IDLE, M_WORD, M_NUM, M_STR, M_STR_FULL, M_CHR_OPEN, M_CHR_CLOSE, M_OP, M_LCOM, M_BCOM
	} mode_t;

	localparam logic [5:0] K_EOF = 6'd0;
	localparam logic [5:0] K_UNKNOWN = 6'd1;
	localparam logic [5:0] K_WORD = 6'd2;
	localparam logic [5:0] K_NUMBER = 6'd3;
	localparam logic [5:0] K_STRING = 6'd4;
	localparam logic [5:0] K_CHAR = 6'd5;

	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_USCORE = 8'h5f;

	typedef struct packed {
		logic [5:0] kind;
		logic [31:0] value;
		logic incl;
	} emit_t;

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		case (c)
			"+": return 6'd6;
			"-": return 6'd9;
			"*": return 6'd13;
			"/": return 6'd15;
			"%": return 6'd17;
			"=": return 6'd18;
			"!": return 6'd20;
			"<": return 6'd22;
			">": return 6'd25;
			"&": return 6'd28;
			"|": return 6'd30;
			"^": return 6'd32;
			"~": return 6'd33;
			"?": return 6'd34;
			":": return 6'd35;
			";": return 6'd36;
			",": return 6'd37;
			".": return 6'd38;
			"(": return 6'd39;
			")": return 6'd40;
			"{": return 6'd41;
			"}": return 6'd42;
			"[": return 6'd43;
			"]": return 6'd44;
			default: return 6'd0;
		endcase
	endfunction

	function automatic logic [5:0] pair_kind(input logic [7:0] c, input logic [7:0] d);
		case (c)
			"+": return (d == "+") ? 6'd7 : (d == "=") ? 6'd8 : 6'd0;
			"-": return (d == "-") ? 6'd10 : (d == "=") ? 6'd11 : (d == ">") ? 6'd12 : 6'd0;
			"*": return (d == "=") ? 6'd14 : 6'd0;
			"/": return (d == "=") ? 6'd16 : 6'd0;
			"=": return (d == "=") ? 6'd19 : 6'd0;
			"!": return (d == "=") ? 6'd21 : 6'd0;
			"<": return (d == "=") ? 6'd23 : (d == "<") ? 6'd24 : 6'd0;
			">": return (d == "=") ? 6'd26 : (d == ">") ? 6'd27 : 6'd0;
			"&": return (d == "&") ? 6'd29 : 6'd0;
			"|": return (d == "|") ? 6'd31 : 6'd0;
			default: return 6'd0;
		endcase
	endfunction

	function automatic logic can_pair(input logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
			c == "!" || c == "<" || c == ">" || c == "&" || c == "|";
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == " " || b == 8'h09 || b == CH_LF || b == 8'h0d;
	endfunction

endpackage

// File: design/clts_core.sv
// scanner state, position tracking and token decision for one byte
module clts_core #(
	parameter int MAX_LEXEME = 64,
	parameter int OFFSET_BITS = 20,
	parameter int POSITION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic func,
	input logic [7:0] source_byte,
	output logic [1:0] n_emit,
	output clts_pkg::emit_t emit_a,
	output clts_pkg::emit_t emit_b,
	output logic [OFFSET_BITS-1:0] start_a,
	output logic [OFFSET_BITS-1:0] start_b,
	output logic [POSITION_BITS-1:0] line_a,
	output logic [POSITION_BITS-1:0] line_b,
	output logic [POSITION_BITS-1:0] col_a,
	output logic [POSITION_BITS-1:0] col_b,
	output logic [OFFSET_BITS-1:0] cur_off
);
	import clts_pkg::*;

	localparam logic [7:0] LIMIT = 8'(MAX_LEXEME - 1);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	mode_t mode_q, mode_d;
	logic [7:0] held_q, held_d;
	logic [31:0] acc_q, acc_d;
	logic hex_q, hex_d, esc_q, esc_d, star_q, star_d;
	logic [OFFSET_BITS-1:0] ts_off_q, ts_off_d, off_q;
	logic [POSITION_BITS-1:0] ts_line_q, ts_line_d, ts_col_q, ts_col_d, line_q, col_q;
	logic [7:0] cnt_q, cnt_d;
	logic fresh;
	logic a_new;
	logic [3:0] hv;
	logic hv_ok;
	logic [7:0] b;
	logic [5:0] pk;
	logic [31:0] mul_acc;

	assign b = source_byte;
	assign cur_off = off_q;
	assign pk = pair_kind(held_q, b);

	always_comb begin
		hv_ok = 1'b1;
		hv = 4'd0;
		if (is_digit(b)) hv = 4'(b - "0");
		else if (b >= "a" && b <= "f") hv = 4'(b - "a" + 8'd10);
		else if (b >= "A" && b <= "F") hv = 4'(b - "A" + 8'd10);
		else hv_ok = 1'b0;
		mul_acc = hex_q ? {acc_q[27:0], 4'd0} + {28'd0, hv}
			: {acc_q[28:0], 3'd0} + {acc_q[30:0], 1'b0} + {28'd0, hv};
	end

	// first pass decides whether the byte ends the token; second emit is a fresh start or EOF
	always_comb begin
		mode_d = mode_q;
		held_d = held_q;
		acc_d = acc_q;
		hex_d = hex_q;
		esc_d = esc_q;
		star_d = star_q;
		ts_off_d = ts_off_q;
		ts_line_d = ts_line_q;
		ts_col_d = ts_col_q;
		cnt_d = cnt_q;
		n_emit = 2'd0;
		emit_a = '0;
		emit_b = '0;
		fresh = 1'b0;
		a_new = 1'b0;
		if (func) begin
			unique case (mode_q)
				M_WORD: begin n_emit = 2'd1; emit_a.kind = K_WORD; end
				M_NUM: begin n_emit = 2'd1; emit_a.kind = K_NUMBER; emit_a.value = acc_q; end
				M_STR, M_STR_FULL: begin n_emit = 2'd1; emit_a.kind = K_STRING; end
				M_CHR_OPEN: begin n_emit = 2'd1; emit_a.kind = K_CHAR; end
				M_CHR_CLOSE: begin n_emit = 2'd1; emit_a.kind = K_CHAR; emit_a.value = acc_q; end
				M_OP: begin n_emit = 2'd1; emit_a.kind = single_kind(held_q); end
				default: ;
			endcase
			if (n_emit == 2'd1) emit_b = '0;
			else begin
				emit_a = '0;
				a_new = 1'b1;
			end
			n_emit = n_emit + 2'd1;
			mode_d = M_IDLE;
			esc_d = 1'b0;
			star_d = 1'b0;
			hex_d = 1'b0;
			ts_off_d = off_q;
			ts_line_d = line_q;
			ts_col_d = col_q;
			cnt_d = '0;
		end else begin
			unique case (mode_q)
				M_WORD: begin
					if (is_alpha(b) || is_digit(b) || b == CH_USCORE) begin
						cnt_d = cnt_q + 8'd1;
						if (cnt_d >= LIMIT) begin
							n_emit = 2'd1; emit_a.kind = K_WORD; emit_a.incl = 1'b1;
							mode_d = M_IDLE;
						end
					end else begin
						n_emit = 2'd1; emit_a.kind = K_WORD; fresh = 1'b1;
					end
				end
				M_NUM: begin
					if (!hex_q && cnt_q == 8'd1 && acc_q == 32'd0 && (b == "x" || b == "X")) begin
						hex_d = 1'b1;
						cnt_d = 8'd2;
					end else if ((hex_q && hv_ok) || (!hex_q && is_digit(b))) begin
						acc_d = mul_acc;
						cnt_d = cnt_q + 8'd1;
					end else begin
						n_emit = 2'd1; emit_a.kind = K_NUMBER; emit_a.value = acc_q;
						fresh = 1'b1;
					end
					if (!fresh && cnt_d >= LIMIT) begin
						n_emit = 2'd1; emit_a.kind = K_NUMBER; emit_a.value = acc_d;
						emit_a.incl = 1'b1; mode_d = M_IDLE;
					end
				end
				M_STR: begin
					if (esc_q) begin
						esc_d = 1'b0;
						cnt_d = cnt_q + ((b == "n" || b == "t" || b == "0" || b == CH_BSLASH
							|| b == "\"") ? 8'd1 : 8'd2);
						if (cnt_d >= LIMIT) mode_d = M_STR_FULL;
					end else if (b == "\"") begin
						n_emit = 2'd1; emit_a.kind = K_STRING; emit_a.incl = 1'b1;
						mode_d = M_IDLE;
					end else if (b == CH_BSLASH) begin
						esc_d = 1'b1;
					end else begin
						cnt_d = cnt_q + 8'd1;
						if (cnt_d >= LIMIT) mode_d = M_STR_FULL;
					end
				end
				M_STR_FULL: begin
					n_emit = 2'd1; emit_a.kind = K_STRING;
					if (b == "\"") begin emit_a.incl = 1'b1; mode_d = M_IDLE; end
					else fresh = 1'b1;
				end
				M_CHR_OPEN: begin
					if (esc_q) begin
						esc_d = 1'b0;
						acc_d = (b == "n") ? 32'd10 : (b == "t") ? 32'd9 : (b == "0") ? 32'd0
							: {24'd0, b};
						mode_d = M_CHR_CLOSE;
					end else if (b == CH_BSLASH) begin
						esc_d = 1'b1;
					end else begin
						acc_d = {24'd0, b};
						mode_d = M_CHR_CLOSE;
					end
				end
				M_CHR_CLOSE: begin
					n_emit = 2'd1; emit_a.kind = K_CHAR; emit_a.value = acc_q;
					if (b == "'") begin emit_a.incl = 1'b1; mode_d = M_IDLE; end
					else fresh = 1'b1;
				end
				M_OP: begin
					if (pk != 6'd0) begin
						n_emit = 2'd1; emit_a.kind = pk; emit_a.incl = 1'b1; mode_d = M_IDLE;
					end else if (held_q == "/" && b == "/") begin
						mode_d = M_LCOM;
					end else if (held_q == "/" && b == "*") begin
						star_d = 1'b0; mode_d = M_BCOM;
					end else begin
						n_emit = 2'd1; emit_a.kind = single_kind(held_q); fresh = 1'b1;
					end
				end
				M_LCOM: if (b == CH_LF) mode_d = M_IDLE;
				M_BCOM: begin
					if (star_q && b == "/") mode_d = M_IDLE;
					else star_d = (b == "*");
				end
				default: fresh = 1'b1;
			endcase
			if (fresh) begin
				mode_d = M_IDLE;
				if (!is_blank(b)) begin
					ts_off_d = off_q;
					ts_line_d = line_q;
					ts_col_d = col_q;
					cnt_d = '0;
					if (b == "\"") begin
						esc_d = 1'b0; mode_d = M_STR;
					end else if (b == "'") begin
						esc_d = 1'b0; acc_d = '0; mode_d = M_CHR_OPEN;
					end else if (is_digit(b)) begin
						hex_d = 1'b0; acc_d = {28'd0, hv}; cnt_d = 8'd1;
						if (cnt_d >= LIMIT) begin
							n_emit = n_emit + 2'd1; emit_b.kind = K_NUMBER; emit_b.value = acc_d;
							emit_b.incl = 1'b1;
						end else mode_d = M_NUM;
					end else if (is_alpha(b) || b == CH_USCORE) begin
						cnt_d = 8'd1;
						if (cnt_d >= LIMIT) begin
							n_emit = n_emit + 2'd1; emit_b.kind = K_WORD; emit_b.incl = 1'b1;
						end else mode_d = M_WORD;
					end else if (can_pair(b)) begin
						held_d = b; mode_d = M_OP;
					end else begin
						n_emit = n_emit + 2'd1;
						emit_b.incl = 1'b1;
						emit_b.kind = (single_kind(b) != 6'd0) ? single_kind(b) : K_UNKNOWN;
					end
					if (n_emit == 2'd1 && mode_q == M_IDLE) begin
						emit_a = emit_b;
						a_new = 1'b1;
					end
				end
			end
		end
	end

	// a lone token that starts at this byte takes the new start position
	assign start_a = a_new ? ts_off_d : ts_off_q;
	assign line_a = a_new ? ts_line_d : ts_line_q;
	assign col_a = a_new ? ts_col_d : ts_col_q;
	assign start_b = ts_off_d;
	assign line_b = ts_line_d;
	assign col_b = ts_col_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			held_q <= '0;
			acc_q <= '0;
			hex_q <= 1'b0;
			esc_q <= 1'b0;
			star_q <= 1'b0;
			ts_off_q <= '0;
			ts_line_q <= POSITION_BITS'(1);
			ts_col_q <= POSITION_BITS'(1);
			cnt_q <= '0;
			off_q <= '0;
			line_q <= POSITION_BITS'(1);
			col_q <= POSITION_BITS'(1);
		end else if (take) begin
			mode_q <= mode_d;
			held_q <= held_d;
			acc_q <= acc_d;
			hex_q <= hex_d;
			esc_q <= esc_d;
			star_q <= star_d;
			ts_off_q <= ts_off_d;
			ts_line_q <= ts_line_d;
			ts_col_q <= ts_col_d;
			cnt_q <= cnt_d;
			if (!func) begin
				off_q <= off_q + OFFSET_BITS'(1);
				if (b == CH_LF) begin
					if (line_q != POS_MAX) line_q <= line_q + POSITION_BITS'(1);
					col_q <= POSITION_BITS'(1);
				end else if (col_q != POS_MAX) begin
					col_q <= col_q + POSITION_BITS'(1);
				end
			end
		end
	end

	a_line_pos: assert property (@(posedge clk) disable iff (!arst_n) line_q != '0)
		else $error("line counter reached zero");
	a_col_pos: assert property (@(posedge clk) disable iff (!arst_n) col_q != '0)
		else $error("column counter reached zero");
	a_eof_one: assert property (@(posedge clk) disable iff (!arst_n)
		take && func |=> mode_q == M_IDLE && !esc_q)
		else $error("end word left scanner busy");
endmodule

// File: design/clts_outq.sv
// two-entry token queue that spreads a byte's tokens over output cycles
module clts_outq #(
	parameter int OFFSET_BITS = 20,
	parameter int POSITION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [1:0] n_push,
	input clts_pkg::emit_t emit_a,
	input clts_pkg::emit_t emit_b,
	input logic [OFFSET_BITS-1:0] start_a,
	input logic [OFFSET_BITS-1:0] start_b,
	input logic [POSITION_BITS-1:0] line_a,
	input logic [POSITION_BITS-1:0] line_b,
	input logic [POSITION_BITS-1:0] col_a,
	input logic [POSITION_BITS-1:0] col_b,
	input logic [OFFSET_BITS-1:0] cur_off,
	output logic room,
	output logic out_valid,
	input logic out_ready,
	output logic [5:0] token_kind,
	output logic signed [31:0] token_value,
	output logic [OFFSET_BITS-1:0] start_offset,
	output logic [7:0] token_length,
	output logic [POSITION_BITS-1:0] start_line,
	output logic [POSITION_BITS-1:0] start_column,
	output logic last_of_run
);
	import clts_pkg::*;

	typedef struct packed {
		logic [5:0] kind;
		logic [31:0] value;
		logic [OFFSET_BITS-1:0] off;
		logic [7:0] len;
		logic [POSITION_BITS-1:0] line;
		logic [POSITION_BITS-1:0] col;
		logic last;
	} ent_t;

	ent_t ent_q [2];
	logic [1:0] cnt_q;
	ent_t ea, eb;
	logic pop;

	function automatic logic [7:0] sat_len(input logic [OFFSET_BITS-1:0] d);
		return (d > OFFSET_BITS'(255)) ? 8'd255 : 8'(d);
	endfunction

	always_comb begin
		ea.kind = emit_a.kind;
		ea.value = emit_a.value;
		ea.off = start_a;
		ea.len = (emit_a.kind == K_EOF) ? 8'd0
			: sat_len(cur_off + OFFSET_BITS'(emit_a.incl) - start_a);
		ea.line = line_a;
		ea.col = col_a;
		ea.last = (n_push == 2'd1);
		eb.kind = emit_b.kind;
		eb.value = emit_b.value;
		eb.off = start_b;
		eb.len = (emit_b.kind == K_EOF) ? 8'd0
			: sat_len(cur_off + OFFSET_BITS'(emit_b.incl) - start_b);
		eb.line = line_b;
		eb.col = col_b;
		eb.last = 1'b1;
	end

	assign pop = out_valid && out_ready;
	assign out_valid = cnt_q != 2'd0;
	assign room = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign token_kind = ent_q[0].kind;
	assign token_value = ent_q[0].value;
	assign start_offset = ent_q[0].off;
	assign token_length = ent_q[0].len;
	assign start_line = ent_q[0].line;
	assign start_column = ent_q[0].col;
	assign last_of_run = ent_q[0].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= 2'd0;
		else cnt_q <= cnt_q - {1'b0, pop} + (push ? n_push : 2'd0);
	end

	always_ff @(posedge clk) begin
		if (push && n_push != 2'd0) begin
			ent_q[0] <= ea;
			ent_q[1] <= eb;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("token queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push && n_push != 2'd0 |-> cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))
		else $error("push onto full queue");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd1 && out_valid |-> last_of_run)
		else $error("lone token not last");
endmodule

// File: design/c_like_token_scanner.sv
// top level of the c-like token scanner
// a token is registered and appears in the cycle after the word that ends it is taken
// throughput: one word per cycle while results are drained; two tokens from
// one word leave the queue one at a time and hold input for the second
// the two-entry token queue sets the rate
// reset: asynchronous, scanner idle at line 1 column 1 offset 0, queue empty
module c_like_token_scanner #(
	parameter int MAX_LEXEME = 64,
	parameter int OFFSET_BITS = 20,
	parameter int POSITION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic func,
	input logic [7:0] source_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [5:0] token_kind,
	output logic signed [31:0] token_value,
	output logic [OFFSET_BITS-1:0] start_offset,
	output logic [7:0] token_length,
	output logic [POSITION_BITS-1:0] start_line,
	output logic [POSITION_BITS-1:0] start_column,
	output logic last_of_run
);
	import clts_pkg::*;

	logic take, room;
	logic [1:0] n_emit;
	emit_t emit_a, emit_b;
	logic [OFFSET_BITS-1:0] start_a, start_b, cur_off;
	logic [POSITION_BITS-1:0] line_a, line_b, col_a, col_b;

	assign in_ready = room;
	assign take = in_valid && in_ready;

	clts_core #(.MAX_LEXEME(MAX_LEXEME), .OFFSET_BITS(OFFSET_BITS),
		.POSITION_BITS(POSITION_BITS)) u_core (
		.clk, .arst_n, .take, .func, .source_byte, .n_emit, .emit_a, .emit_b,
		.start_a, .start_b, .line_a, .line_b, .col_a, .col_b, .cur_off
	);

	clts_outq #(.OFFSET_BITS(OFFSET_BITS), .POSITION_BITS(POSITION_BITS)) u_outq (
		.clk, .arst_n, .push(take), .n_push(n_emit), .emit_a, .emit_b,
		.start_a, .start_b, .line_a, .line_b, .col_a, .col_b, .cur_off, .room,
		.out_valid, .out_ready, .token_kind, .token_value, .start_offset,
		.token_length, .start_line, .start_column, .last_of_run
	);

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !last_of_run |-> !in_ready)
		else $error("input taken behind pending pair");
	a_eof_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == K_EOF |-> token_length == 8'd0 && last_of_run)
		else $error("bad eof token");
	a_start_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> start_line != '0)
		else $error("token line zero");
endmodule

// File: tb/c_like_token_scanner_checker.sv
// token checker: predicts scanner tokens from accepted words and compares them
`timescale 1ns / 100ps
module c_like_token_scanner_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic func,
	input logic [7:0] source_byte,
	input logic out_valid,
	input logic out_ready,
	input logic [5:0] token_kind,
	input logic signed [31:0] token_value,
	input logic [19:0] start_offset,
	input logic [7:0] token_length,
	input logic [15:0] start_line,
	input logic [15:0] start_column,
	input logic last_of_run,
	output int fail_count,
	output int pending_tokens,
	output int token_total
);
	import clts_pkg::*;

	localparam int LEX_LIMIT = 63;

	typedef struct packed {
		logic [5:0] kind;
		logic [31:0] value;
		logic [19:0] offset;
		logic [7:0] length;
		logic [15:0] line;
		logic [15:0] column;
		logic last;
	} token_t;

	token_t tok_q[$];
	token_t run_toks[$];

	mode_t mode;
	logic [7:0] held_op;
	logic [31:0] acc;
	logic hex_flag, esc_pend, star_seen;
	logic [19:0] tok_off, cur_off;
	logic [15:0] tok_line, tok_col, cur_line, cur_col;
	logic [7:0] lex_cnt;

	function automatic int hex_digit(input logic [7:0] b);
		if (is_digit(b)) return b - "0";
		if (b >= "a" && b <= "f") return b - "a" + 10;
		if (b >= "A" && b <= "F") return b - "A" + 10;
		return -1;
	endfunction

	task automatic push_token(input logic [5:0] kind, input logic [31:0] value, input bit incl);
		token_t t;
		logic [19:0] span;
		if (run_toks.size() >= 2) return;
		span = cur_off + incl - tok_off;
		t.kind = kind;
		t.value = value;
		t.offset = tok_off;
		t.length = (span > 255) ? 8'd255 : span[7:0];
		t.line = tok_line;
		t.column = tok_col;
		t.last = 1'b0;
		run_toks.push_back(t);
	endtask

	task automatic mark_start();
		tok_off = cur_off;
		tok_line = cur_line;
		tok_col = cur_col;
		lex_cnt = 0;
	endtask

	task automatic begin_token(input logic [7:0] b);
		mode = M_IDLE;
		if (is_blank(b)) return;
		mark_start();
		if (b == "\"") begin
			esc_pend = 0;
			mode = M_STR;
		end else if (b == "'") begin
			esc_pend = 0;
			acc = 0;
			mode = M_CHR_OPEN;
		end else if (is_digit(b)) begin
			hex_flag = 0;
			acc = b - "0";
			lex_cnt = 1;
			mode = M_NUM;
		end else if (is_alpha(b) || b == CH_USCORE) begin
			lex_cnt = 1;
			mode = M_WORD;
		end else if (can_pair(b)) begin
			held_op = b;
			mode = M_OP;
		end else if (single_kind(b) != 0) begin
			push_token(single_kind(b), 0, 1);
		end else begin
			push_token(K_UNKNOWN, 0, 1);
		end
	endtask

	task automatic scan_char(input logic [7:0] b);
		logic [5:0] k;
		case (mode)
			M_WORD: begin
				if (is_alpha(b) || is_digit(b) || b == CH_USCORE) begin
					lex_cnt++;
					if (lex_cnt >= LEX_LIMIT) begin
						push_token(K_WORD, 0, 1);
						mode = M_IDLE;
					end
				end else begin
					push_token(K_WORD, 0, 0);
					begin_token(b);
				end
			end
			M_NUM: begin
				if (!hex_flag && lex_cnt == 1 && acc == 0 && (b == "x" || b == "X")) begin
					hex_flag = 1;
					lex_cnt = 2;
				end else if (hex_flag && hex_digit(b) >= 0) begin
					acc = acc * 16 + hex_digit(b);
					lex_cnt++;
				end else if (!hex_flag && is_digit(b)) begin
					acc = acc * 10 + (b - "0");
					lex_cnt++;
				end else begin
					push_token(K_NUMBER, acc, 0);
					begin_token(b);
					return;
				end
				if (lex_cnt >= LEX_LIMIT) begin
					push_token(K_NUMBER, acc, 1);
					mode = M_IDLE;
				end
			end
			M_STR: begin
				if (esc_pend) begin
					esc_pend = 0;
					lex_cnt += (b == "n" || b == "t" || b == "0" || b == CH_BSLASH
						|| b == "\"") ? 1 : 2;
				end else if (b == "\"") begin
					push_token(K_STRING, 0, 1);
					mode = M_IDLE;
					return;
				end else if (b == CH_BSLASH) begin
					esc_pend = 1;
					return;
				end else begin
					lex_cnt++;
				end
				if (lex_cnt >= LEX_LIMIT) mode = M_STR_FULL;
			end
			M_STR_FULL: begin
				if (b == "\"") begin
					push_token(K_STRING, 0, 1);
					mode = M_IDLE;
				end else begin
					push_token(K_STRING, 0, 0);
					begin_token(b);
				end
			end
			M_CHR_OPEN: begin
				if (esc_pend) begin
					esc_pend = 0;
					acc = (b == "n") ? 10 : (b == "t") ? 9 : (b == "0") ? 0 : b;
					mode = M_CHR_CLOSE;
				end else if (b == CH_BSLASH) begin
					esc_pend = 1;
				end else begin
					acc = b;
					mode = M_CHR_CLOSE;
				end
			end
			M_CHR_CLOSE: begin
				if (b == "'") begin
					push_token(K_CHAR, acc, 1);
					mode = M_IDLE;
				end else begin
					push_token(K_CHAR, acc, 0);
					begin_token(b);
				end
			end
			M_OP: begin
				k = pair_kind(held_op, b);
				if (k != 0) begin
					push_token(k, 0, 1);
					mode = M_IDLE;
				end else if (held_op == "/" && b == "/") begin
					mode = M_LCOM;
				end else if (held_op == "/" && b == "*") begin
					star_seen = 0;
					mode = M_BCOM;
				end else begin
					push_token(single_kind(held_op), 0, 0);
					begin_token(b);
				end
			end
			M_LCOM: if (b == CH_LF) mode = M_IDLE;
			M_BCOM: begin
				if (star_seen && b == "/") mode = M_IDLE;
				else star_seen = (b == "*");
			end
			default: begin_token(b);
		endcase
	endtask

	task automatic close_text();
		case (mode)
			M_WORD: push_token(K_WORD, 0, 0);
			M_NUM: push_token(K_NUMBER, acc, 0);
			M_STR, M_STR_FULL: push_token(K_STRING, 0, 0);
			M_CHR_OPEN: push_token(K_CHAR, 0, 0);
			M_CHR_CLOSE: push_token(K_CHAR, acc, 0);
			M_OP: push_token(single_kind(held_op), 0, 0);
			default: ;
		endcase
		mode = M_IDLE;
		esc_pend = 0;
		star_seen = 0;
		hex_flag = 0;
		mark_start();
		push_token(K_EOF, 0, 0);
	endtask

	task automatic predict_word(input logic f, input logic [7:0] b);
		run_toks.delete();
		if (f) begin
			close_text();
		end else begin
			scan_char(b);
			cur_off++;
			if (b == CH_LF) begin
				if (cur_line != 16'hffff) cur_line++;
				cur_col = 1;
			end else if (cur_col != 16'hffff) begin
				cur_col++;
			end
		end
		if (run_toks.size() > 0) run_toks[run_toks.size()-1].last = 1'b1;
		foreach (run_toks[i]) tok_q.push_back(run_toks[i]);
	endtask

	task automatic compare_token();
		token_t e;
		if (tok_q.size() == 0) begin
			$error("unexpected token kind %0d at offset %0d", token_kind, start_offset);
			fail_count++;
			return;
		end
		e = tok_q.pop_front();
		if (token_kind !== e.kind) begin
			$error("token_kind expected %0d actual %0d", e.kind, token_kind);
			fail_count++;
		end
		if (token_value !== e.value) begin
			$error("token_value expected %0d actual %0d", $signed(e.value), token_value);
			fail_count++;
		end
		if (start_offset !== e.offset) begin
			$error("start_offset expected %0d actual %0d", e.offset, start_offset);
			fail_count++;
		end
		if (token_length !== e.length) begin
			$error("token_length expected %0d actual %0d", e.length, token_length);
			fail_count++;
		end
		if (start_line !== e.line) begin
			$error("start_line expected %0d actual %0d", e.line, start_line);
			fail_count++;
		end
		if (start_column !== e.column) begin
			$error("start_column expected %0d actual %0d", e.column, start_column);
			fail_count++;
		end
		if (last_of_run !== e.last) begin
			$error("last_of_run expected %0d actual %0d", e.last, last_of_run);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		token_total = 0;
		mode = M_IDLE;
		held_op = 0;
		acc = 0;
		hex_flag = 0;
		esc_pend = 0;
		star_seen = 0;
		tok_off = 0;
		tok_line = 1;
		tok_col = 1;
		lex_cnt = 0;
		cur_off = 0;
		cur_line = 1;
		cur_col = 1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				compare_token();
				token_total++;
			end
			if (in_valid && in_ready) predict_word(func, source_byte);
		end
	end

	assign pending_tokens = tok_q.size();

endmodule

// File: tb/c_like_token_scanner_tb.sv
// testbench top: drives source words into the token scanner and gives the verdict
`timescale 1ns / 100ps
module c_like_token_scanner_tb;
	import clts_pkg::*;

	localparam int RANDOM_WORDS = 1100;
	localparam int CYCLE_LIMIT = 200000;

	logic clk, arst_n;
	logic in_valid, in_ready, func;
	logic [7:0] source_byte;
	logic out_valid, out_ready;
	logic [5:0] token_kind;
	logic signed [31:0] token_value;
	logic [19:0] start_offset;
	logic [7:0] token_length;
	logic [15:0] start_line, start_column;
	logic last_of_run;
	int fail_count, pending_tokens, token_total;
	int cycle_count;
	int word_total;
	bit hold_off_req, hold_off_done;

	c_like_token_scanner u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .source_byte(source_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .token_value(token_value),
		.start_offset(start_offset), .token_length(token_length),
		.start_line(start_line), .start_column(start_column),
		.last_of_run(last_of_run)
	);

	c_like_token_scanner_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .source_byte(source_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .token_value(token_value),
		.start_offset(start_offset), .token_length(token_length),
		.start_line(start_line), .start_column(start_column),
		.last_of_run(last_of_run),
		.fail_count(fail_count), .pending_tokens(pending_tokens),
		.token_total(token_total)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int mode_sel, n;
		out_ready = 0;
		hold_off_done = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req && !hold_off_done) begin
				out_ready <= 0;
				repeat (60) @(posedge clk);
				hold_off_done = 1;
			end
			mode_sel = $urandom_range(0, 3);
			n = $urandom_range(1, 30);
			repeat (n) begin
				case (mode_sel)
					0: out_ready <= 1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic send_word(input logic f, input logic [7:0] b);
		in_valid <= 1;
		func <= f;
		source_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		word_total++;
	endtask

	task automatic maybe_gap();
		int g;
		if ($urandom_range(0, 5) == 0) begin
			g = $urandom_range(1, 6);
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		foreach (s[i]) begin
			send_word(0, s[i]);
			maybe_gap();
		end
	endtask

	function automatic logic [7:0] pick_char(input int cls);
		string ops = "+-*/%=!<>&|^~?:;,.(){}[]";
		string hx = "0123456789abcdefABCDEFxX";
		case (cls)
			0: return 8'($urandom_range("a", "z"));
			1: return 8'($urandom_range("0", "9"));
			2: return ops[$urandom_range(0, ops.len() - 1)];
			3: return hx[$urandom_range(0, hx.len() - 1)];
			4: return $urandom_range(0, 1) ? " " : CH_LF;
			5: return 8'($urandom_range(0, 255));
			6: return $urandom_range(0, 1) ? "\"" : "'";
			7: return CH_BSLASH;
			default: return $urandom_range(0, 1) ? CH_USCORE : "\t";
		endcase
	endfunction

	initial begin
		string s;
		int n, cls;
		arst_n = 0;
		in_valid = 0;
		func = 0;
		source_byte = 0;
		word_total = 0;
		hold_off_req = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		send_text("a_1 0x1F 0X 99 \"a\\n\\q\" 'c' '\\t' 'ab");
		send_word(0, 8'h00);
		send_word(0, 8'hff);
		send_text(" += -> >>= <<= && || != == ++ -- *= /= % ^ ~ ? : ; , . ( ) { } [ ]");
		send_text("// c\nx/*a**/y/*");
		send_word(1, 0);
		send_text("4294967296 \"");
		send_word(1, 0);
		send_word(1, 8'hff);
		s = "";
		repeat (70) s = {s, "w"};
		send_text({s, " "});
		s = "";
		repeat (70) s = {s, "7"};
		send_text(s);
		s = "\"";
		repeat (40) s = {s, "\\q"};
		send_text({s, "\"x\""});
		send_text("'");
		send_word(1, 0);

		// random text, with a long receiver hold-off partway
		while (word_total < RANDOM_WORDS) begin
			if (word_total > 700) hold_off_req = 1;
			n = $urandom_range(1, 12);
			cls = $urandom_range(0, 9);
			if (cls == 9) begin
				send_word(1, 8'($urandom_range(0, 255)));
			end else begin
				repeat (n) begin
					if ($urandom_range(0, 3) == 0) send_word(0, pick_char($urandom_range(0, 8)));
					else send_word(0, pick_char(cls));
				end
			end
			maybe_gap();
		end
		send_word(1, 0);
		in_valid <= 0;

		while (pending_tokens != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("scanned %0d words, checked %0d tokens", word_total, token_total);
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
